// ===== rtl/sbe_pkg.sv =====
// Shared constants for the stochastic CPU budget estimator.
// No dependencies; used by the divider cell, the top level, the checker and the bench.
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;

    localparam int DEF_OUT_FRAC_BITS = 16;
    localparam int IN_W              = 272;
    localparam int BUDGET_W          = 48;
    localparam int USER_W            = 2;
    localparam int PER_W             = 32;
    localparam int LOAD_W            = 64;
    localparam int LOAD_FRAC         = 8;

    localparam logic [BUDGET_W-1:0] MAX_BUDGET = {BUDGET_W{1'b1}};

    // m_tuser bit positions
    localparam int USR_SAT = 0;
    localparam int USR_ZD  = 1;

endpackage
`default_nettype wire

// ===== rtl/sbe_sqrt_cell.sv =====
// One radix-2 digit of a restoring integer square root, registered.
// Uses no package; instantiated in rows by the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbe_sqrt_cell #(
    parameter int RAD_W  = 64,
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire logic [ROOT_W+1:0] in_rem,
    input  wire logic [ROOT_W-1:0] in_root,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [RAD_W-1:0]       out_rad,
    output logic [ROOT_W+1:0]      out_rem,
    output logic [ROOT_W-1:0]      out_root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic             valid_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [REM_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        rem_sh    = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
        trial     = {in_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {in_rad[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== rtl/sbe_div_cell.sv =====
// One quotient bit of a restoring divider, registered; folds bits past 48 into a flag.
// Depends on sbe_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module sbe_div_cell #(
    parameter int DVD_W = 72
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [DVD_W-1:0]             in_dvd,
    input  wire logic [sbe_pkg::PER_W-1:0]    in_rem,
    input  wire logic [sbe_pkg::BUDGET_W-1:0] in_q,
    input  wire logic                         in_ovf,
    input  wire logic [sbe_pkg::PER_W-1:0]    in_per,
    output logic                              out_valid,
    output logic [DVD_W-1:0]                  out_dvd,
    output logic [sbe_pkg::PER_W-1:0]         out_rem,
    output logic [sbe_pkg::BUDGET_W-1:0]      out_q,
    output logic                              out_ovf,
    output logic [sbe_pkg::PER_W-1:0]         out_per
);

    localparam int PW = sbe_pkg::PER_W;
    localparam int QW = sbe_pkg::BUDGET_W;

    logic [PW:0]    rem_sh;
    logic [PW:0]    diff;
    logic           ge;
    logic           valid_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [PW-1:0]  rem_reg;
    logic [QW-1:0]  q_reg;
    logic           ovf_reg;
    logic [PW-1:0]  per_reg;

    always_comb
    begin
        rem_sh = {in_rem, in_dvd[DVD_W-1]};
        diff   = rem_sh - {1'b0, in_per};
        ge     = (rem_sh >= {1'b0, in_per});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg <= {in_dvd[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? diff[PW-1:0] : rem_sh[PW-1:0];
            q_reg   <= {in_q[QW-2:0], ge};
            ovf_reg <= in_ovf | in_q[QW-1];
            per_reg <= in_per;
        end
    end

    assign out_valid = valid_reg;
    assign out_dvd   = dvd_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_ovf   = ovf_reg;
    assign out_per   = per_reg;

endmodule
`default_nettype wire

// ===== rtl/stochastic_cpu_budget_estimator_core.sv =====
// Top level of the stochastic CPU budget estimator: two square-root cell rows,
// the mean/variance and alpha stages, and a divider cell row. Uses sbe_pkg and the cells.
//
// Usage:
//   Slave channel (s_*) takes one task's statistics per item; master channel
//   (m_*) returns one budget item per input item, in order.
//   Pipeline: 32 square-root cells on the head variance, one sum stage,
//   40 square-root cells on the total variance, one multiply stage, one add
//   stage, 56 + OUT_FRAC_BITS divider cells and the output register.
//   Throughput is one item per cycle while the output is not stalled;
//   every cell row advances together.
//   The whole row advances when the output register is empty or being taken,
//   so a stalled receiver holds every stage in place and s_tready drops in
//   the same cycle; nothing is dropped or repeated.
//   Reset clears all valid flags; no clearing pass is needed.
//   An empty queue gives budget 0; periods_left of zero gives the maximum
//   budget with zero_divisor set; a quotient past 48 bits saturates.
`timescale 1ns / 1ps
`default_nettype none
module stochastic_cpu_budget_estimator_core #(
    parameter int OUT_FRAC_BITS = sbe_pkg::DEF_OUT_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [15:0] jobs_queued, [47:16] runtime_so_far, [79:48] head_mean,
    // [111:80] tail_mean, [159:112] head_variance, [207:160] tail_variance,
    // [239:208] confidence_factor, [271:240] periods_left
    input  wire logic [sbe_pkg::IN_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [47:0] budget
    output logic [sbe_pkg::BUDGET_W-1:0]      m_tdata,
    // [0] saturated, [1] zero_divisor
    output logic [sbe_pkg::USER_W-1:0]        m_tuser
);

    localparam int SHIFT   = OUT_FRAC_BITS - sbe_pkg::LOAD_FRAC;
    localparam int DIV_N   = sbe_pkg::LOAD_W + SHIFT;
    localparam int S1_RAD  = 64;
    localparam int S1_ROOT = 32;
    localparam int S1_N    = S1_RAD / 2;
    localparam int S1_SIDE = sbe_pkg::IN_W;
    localparam int S2_RAD  = 80;
    localparam int S2_ROOT = 40;
    localparam int S2_N    = S2_RAD / 2;
    localparam int S2_SIDE = 1 + 32 + 32 + 64;
    localparam int PW      = sbe_pkg::PER_W;
    localparam int QW      = sbe_pkg::BUDGET_W;

    logic en;

    // row advances whenever the output slot can take what's behind it
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- head std-dev row ----------------
    logic [S1_N:0]               s1_valid;
    logic [S1_N:0][S1_RAD-1:0]   s1_rad;
    logic [S1_N:0][S1_ROOT+1:0]  s1_rem;
    logic [S1_N:0][S1_ROOT-1:0]  s1_root;
    logic [S1_N:0][S1_SIDE-1:0]  s1_side;

    // side: the whole input item, same bit layout as s_tdata
    assign s1_valid[0] = s_tvalid && en;
    assign s1_rad[0]   = {s_tdata[159:112], 16'h0000};
    assign s1_rem[0]   = '0;
    assign s1_root[0]  = '0;
    assign s1_side[0]  = s_tdata;

    for (genvar i = 0; i < S1_N; i++)
    begin : g_sq1
        sbe_sqrt_cell #(
            .RAD_W  (S1_RAD),
            .ROOT_W (S1_ROOT),
            .SIDE_W (S1_SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s1_valid[i]),
            .in_rad    (s1_rad[i]),
            .in_rem    (s1_rem[i]),
            .in_root   (s1_root[i]),
            .in_side   (s1_side[i]),
            .out_valid (s1_valid[i+1]),
            .out_rad   (s1_rad[i+1]),
            .out_rem   (s1_rem[i+1]),
            .out_root  (s1_root[i+1]),
            .out_side  (s1_side[i+1])
        );
    end

    // ---------------- sum stage ----------------
    logic [15:0] a_n;
    logic [31:0] a_rt, a_m0, a_ml, a_alpha, a_per;
    logic [47:0] a_v0, a_vl;
    logic [31:0] a_sd0;
    logic [39:0] a_diff, a_c0;
    logic [15:0] a_nm1;
    logic [47:0] a_mprod;
    logic [63:0] a_vprod;
    logic [64:0] a_vsum;
    logic [63:0] a_tmean_next;
    logic [63:0] a_tvar_next;

    always_comb
    begin
        a_n     = s1_side[S1_N][15:0];
        a_rt    = s1_side[S1_N][47:16];
        a_m0    = s1_side[S1_N][79:48];
        a_ml    = s1_side[S1_N][111:80];
        a_v0    = s1_side[S1_N][159:112];
        a_vl    = s1_side[S1_N][207:160];
        a_alpha = s1_side[S1_N][239:208];
        a_per   = s1_side[S1_N][271:240];
        a_sd0   = s1_root[S1_N];
        a_diff  = {a_m0 - a_rt, 8'h00};
        // head job: remaining mean, floored at its std-dev
        a_c0    = ((a_m0 > a_rt) && (a_diff > {8'h00, a_sd0})) ? a_diff : {8'h00, a_sd0};
        // n-1 later jobs; n of one gives zero products, n of zero is masked later
        a_nm1   = a_n - 16'd1;
        a_mprod = {32'd0, a_nm1} * {16'd0, a_ml};
        a_vprod = {48'd0, a_nm1} * {16'd0, a_vl};
        a_tmean_next = {24'h000000, a_c0} + {8'h00, a_mprod, 8'h00};
        a_vsum  = {17'd0, a_v0} + {1'b0, a_vprod};
        a_tvar_next = a_vsum[64] ? {64{1'b1}} : a_vsum[63:0];
    end

    logic        a_valid_reg;
    logic [63:0] a_tmean_reg;
    logic [63:0] a_tvar_reg;
    logic        a_nz_reg;
    logic [31:0] a_alpha_reg;
    logic [31:0] a_per_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s1_valid[S1_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_tmean_reg <= a_tmean_next;
            a_tvar_reg  <= a_tvar_next;
            a_nz_reg    <= (a_n != 16'h0000);
            a_alpha_reg <= a_alpha;
            a_per_reg   <= a_per;
        end
    end

    // ---------------- total std-dev row ----------------
    logic [S2_N:0]               s2_valid;
    logic [S2_N:0][S2_RAD-1:0]   s2_rad;
    logic [S2_N:0][S2_ROOT+1:0]  s2_rem;
    logic [S2_N:0][S2_ROOT-1:0]  s2_root;
    logic [S2_N:0][S2_SIDE-1:0]  s2_side;

    assign s2_valid[0] = a_valid_reg;
    assign s2_rad[0]   = {a_tvar_reg, 16'h0000};
    assign s2_rem[0]   = '0;
    assign s2_root[0]  = '0;
    assign s2_side[0]  = {a_nz_reg, a_per_reg, a_alpha_reg, a_tmean_reg};

    for (genvar i = 0; i < S2_N; i++)
    begin : g_sq2
        sbe_sqrt_cell #(
            .RAD_W  (S2_RAD),
            .ROOT_W (S2_ROOT),
            .SIDE_W (S2_SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s2_valid[i]),
            .in_rad    (s2_rad[i]),
            .in_rem    (s2_rem[i]),
            .in_root   (s2_root[i]),
            .in_side   (s2_side[i]),
            .out_valid (s2_valid[i+1]),
            .out_rad   (s2_rad[i+1]),
            .out_rem   (s2_rem[i+1]),
            .out_root  (s2_root[i+1]),
            .out_side  (s2_side[i+1])
        );
    end

    // ---------------- alpha * std stage ----------------
    logic [31:0] b_alpha;
    logic [39:0] b_tsd;

    assign b_alpha = s2_side[S2_N][95:64];
    assign b_tsd   = s2_root[S2_N];

    logic        b_valid_reg;
    logic [63:0] b_lo_reg;
    logic [39:0] b_hi_reg;
    logic [63:0] b_tmean_reg;
    logic [31:0] b_per_reg;
    logic        b_nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= s2_valid[S2_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_lo_reg    <= {32'h0, b_alpha} * {32'h0, b_tsd[31:0]};
            b_hi_reg    <= {8'h00, b_alpha} * {32'h0, b_tsd[39:32]};
            b_tmean_reg <= s2_side[S2_N][63:0];
            b_per_reg   <= s2_side[S2_N][127:96];
            b_nz_reg    <= s2_side[S2_N][128];
        end
    end

    // ---------------- load stage ----------------
    logic [63:0] c_scaled;
    logic [64:0] c_sum;
    logic [63:0] c_load_next;

    always_comb
    begin
        c_scaled = {8'h00, b_hi_reg, 16'h0000} + {16'h0000, b_lo_reg[63:16]};
        c_sum    = {1'b0, b_tmean_reg} + {1'b0, c_scaled};
        if (!b_nz_reg)
        begin
            c_load_next = '0;
        end
        else if (c_sum[64])
        begin
            c_load_next = {64{1'b1}};
        end
        else
        begin
            c_load_next = c_sum[63:0];
        end
    end

    logic        c_valid_reg;
    logic [63:0] c_load_reg;
    logic [31:0] c_per_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_load_reg <= c_load_next;
            c_per_reg  <= b_per_reg;
        end
    end

    // ---------------- divider row ----------------
    logic [DIV_N:0]            d_valid;
    logic [DIV_N:0][DIV_N-1:0] d_dvd;
    logic [DIV_N:0][PW-1:0]    d_rem;
    logic [DIV_N:0][QW-1:0]    d_q;
    logic [DIV_N:0]            d_ovf;
    logic [DIV_N:0][PW-1:0]    d_per;

    assign d_valid[0] = c_valid_reg;
    assign d_dvd[0]   = {c_load_reg, {SHIFT{1'b0}}};
    assign d_rem[0]   = '0;
    assign d_q[0]     = '0;
    assign d_ovf[0]   = 1'b0;
    assign d_per[0]   = c_per_reg;

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_div
        sbe_div_cell #(
            .DVD_W (DIV_N)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d_valid[i]),
            .in_dvd    (d_dvd[i]),
            .in_rem    (d_rem[i]),
            .in_q      (d_q[i]),
            .in_ovf    (d_ovf[i]),
            .in_per    (d_per[i]),
            .out_valid (d_valid[i+1]),
            .out_dvd   (d_dvd[i+1]),
            .out_rem   (d_rem[i+1]),
            .out_q     (d_q[i+1]),
            .out_ovf   (d_ovf[i+1]),
            .out_per   (d_per[i+1])
        );
    end

    // ---------------- output register ----------------
    logic                          out_valid_reg;
    logic [QW-1:0]                 out_budget_reg;
    logic [sbe_pkg::USER_W-1:0]    out_user_reg;
    logic [QW-1:0]                 out_budget_next;
    logic [sbe_pkg::USER_W-1:0]    out_user_next;

    always_comb
    begin
        out_user_next = '0;
        if (d_per[DIV_N] == '0)
        begin
            out_budget_next = sbe_pkg::MAX_BUDGET;
            out_user_next[sbe_pkg::USR_ZD] = 1'b1;
        end
        else if (d_ovf[DIV_N])
        begin
            out_budget_next = sbe_pkg::MAX_BUDGET;
            out_user_next[sbe_pkg::USR_SAT] = 1'b1;
        end
        else
        begin
            out_budget_next = d_q[DIV_N];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid[DIV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_budget_reg <= out_budget_next;
            out_user_reg   <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_budget_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

// ===== rtl/sbe_checker.sv =====
// Port-level checks for the budget estimator, bound to the top level.
// Depends on sbe_pkg and stochastic_cpu_budget_estimator_core.
`timescale 1ns / 1ps
`default_nettype none
module sbe_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [sbe_pkg::BUDGET_W-1:0] m_tdata,
    input wire logic [sbe_pkg::USER_W-1:0]   m_tuser
);

    // a held result blocks intake, a free output slot always opens it
    a_ready_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output slot");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[sbe_pkg::USR_SAT] && m_tuser[sbe_pkg::USR_ZD]))
        else $error("saturated and zero_divisor both set");

    a_flag_gives_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != '0)) |-> (m_tdata == sbe_pkg::MAX_BUDGET))
        else $error("flagged result is not maximum budget");

endmodule

bind stochastic_cpu_budget_estimator_core sbe_checker u_sbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for stochastic_cpu_budget_estimator_core: directed corner items,
// random load statistics, and backpressure, checked against a budget predictor.
// Depends on sbe_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb;
    import sbe_pkg::*;

    localparam int FRAC      = DEF_OUT_FRAC_BITS;
    localparam int SHIFT     = FRAC - LOAD_FRAC;
    localparam int LATENCY   = 132 + FRAC;
    localparam int LONG_HOLD = 400;

    // packed exactly as s_tdata, lowest field last
    typedef struct packed {
        logic [31:0] periods_left;
        logic [31:0] alpha;
        logic [47:0] tail_var;
        logic [47:0] head_var;
        logic [31:0] tail_mean;
        logic [31:0] head_mean;
        logic [31:0] runtime;
        logic [15:0] jobs;
    } task_stats_t;

    typedef struct packed {
        logic [47:0] budget;
        logic        saturated;
        logic        zero_div;
    } budget_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [BUDGET_W-1:0] m_tdata;
    logic [USER_W-1:0]   m_tuser;

    budget_t expected_budgets[$];
    int      errors;
    bit      quiet;
    int      hold_cycles;

    stochastic_cpu_budget_estimator_core #(.OUT_FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // floor square root of an 80-bit value, digit pair by digit pair
    function automatic logic [63:0] root80(logic [79:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 39; i >= 0; i--)
        begin
            rem   = (rem << 2) | 64'(v[2*i +: 2]);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic budget_t predict_budget(task_stats_t x);
        budget_t     r;
        logic [63:0] sd_head, head_load, rem_mean, tot_mean, tot_var, tot_sd, others, load;
        logic [127:0] prod, quo;
        r = '0;
        if (x.periods_left == 0)
        begin
            r.budget   = MAX_BUDGET;
            r.zero_div = 1'b1;
            return r;
        end
        load = '0;
        if (x.jobs != 0)
        begin
            sd_head   = root80({x.head_var, 16'h0});
            head_load = sd_head;
            // remaining head load never drops below its std deviation
            if (x.head_mean > x.runtime)
            begin
                rem_mean = 64'(x.head_mean - x.runtime) << LOAD_FRAC;
                if (rem_mean > sd_head)
                    head_load = rem_mean;
            end
            tot_mean = head_load;
            tot_var  = 64'(x.head_var);
            if (x.jobs > 1)
            begin
                others   = 64'(x.jobs) - 64'd1;
                tot_mean = add_sat64(tot_mean, (others * 64'(x.tail_mean)) << LOAD_FRAC);
                tot_var  = add_sat64(tot_var, others * 64'(x.tail_var));
            end
            tot_sd = root80({tot_var, 16'h0});
            prod   = 128'(x.alpha) * 128'(tot_sd);
            load   = add_sat64(tot_mean, prod[79:16]);
        end
        quo = (128'(load) << SHIFT) / 128'(x.periods_left);
        if (quo > 128'(MAX_BUDGET))
        begin
            r.budget    = MAX_BUDGET;
            r.saturated = 1'b1;
        end
        else
            r.budget = quo[47:0];
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [63:0] pick_value(int w);
        logic [63:0] v;
        logic [63:0] mask;
        mask = (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
        case ($urandom_range(0, 6))
            0:       v = '0;
            1:       v = mask;
            2:       v = 64'($urandom_range(1, 255));
            3:       v = 64'($urandom_range(256, 1 << 20));
            default: v = {$urandom, $urandom};
        endcase
        return v & mask;
    endfunction

    function automatic task_stats_t make_stats(logic [15:0] n, logic [31:0] rt,
                                               logic [31:0] m0, logic [31:0] ml,
                                               logic [47:0] v0, logic [47:0] vl,
                                               logic [31:0] a, logic [31:0] per);
        task_stats_t x;
        x.jobs = n; x.runtime = rt; x.head_mean = m0; x.tail_mean = ml;
        x.head_var = v0; x.tail_var = vl; x.alpha = a; x.periods_left = per;
        return x;
    endfunction

    // mostly plausible task statistics, with some fully random noise
    function automatic task_stats_t random_stats();
        task_stats_t x;
        if ($urandom_range(0, 3) == 0)
        begin
            x.jobs         = 16'(pick_value(16));
            x.runtime      = 32'(pick_value(32));
            x.head_mean    = 32'(pick_value(32));
            x.tail_mean    = 32'(pick_value(32));
            x.head_var     = 48'(pick_value(48));
            x.tail_var     = 48'(pick_value(48));
            x.alpha        = 32'(pick_value(32));
            x.periods_left = 32'(pick_value(32));
        end
        else
        begin
            x.jobs         = 16'($urandom_range(0, 12));
            x.head_mean    = $urandom_range(1000, 2000000);
            x.runtime      = $urandom_range(0, x.head_mean + 500000);
            x.tail_mean    = $urandom_range(1000, 2000000);
            x.head_var     = 48'($urandom_range(0, 32'hFFFFFF)) * 48'($urandom_range(0, 4096));
            x.tail_var     = 48'($urandom_range(0, 32'hFFFFFF)) * 48'($urandom_range(0, 4096));
            x.alpha        = $urandom_range(0, 5 << 16);
            x.periods_left = $urandom_range(0, 50) == 0 ? 32'd0 : $urandom_range(1, 1000);
        end
        return x;
    endfunction

    // ---------------- driver ----------------
    // called at a rising edge; returns once the item is accepted and any idle gap is over
    task automatic send_stats(task_stats_t x);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_budgets.push_back(predict_budget(x));
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_budgets.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- receiver ----------------
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ---------------- checker ----------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_budgets.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: budget=%h user=%b", m_tdata, m_tuser);
            end
            else
            begin
                budget_t e;
                e = expected_budgets.pop_front();
                if (m_tdata !== e.budget || m_tuser[USR_SAT] !== e.saturated ||
                    m_tuser[USR_ZD] !== e.zero_div)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: budget exp %h got %h, sat exp %b got %b, zd exp %b got %b",
                                 e.budget, m_tdata, e.saturated, m_tuser[USR_SAT],
                                 e.zero_div, m_tuser[USR_ZD]);
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_corners();
        logic [31:0] m32;
        logic [47:0] m48;
        m32 = '1;
        m48 = '1;
        send_stats(make_stats(0, 0, 0, 0, 0, 0, 0, 1));                  // empty queue
        send_stats(make_stats(0, m32, m32, m32, m48, m48, m32, 7));      // empty, big stats
        send_stats(make_stats(0, 5, 9, 3, 4, 4, 1 << 16, 0));            // zero divisor, empty
        send_stats(make_stats(3, 100, 5000, 200, 900, 900, 1 << 16, 0)); // zero divisor
        send_stats(make_stats(1, 0, 1000, 0, 0, 0, 0, 1));               // mean only
        send_stats(make_stats(1, 5000, 1000, 0, 10000, 0, 1 << 16, 1));  // runtime past mean
        send_stats(make_stats(1, 999, 1000, 0, 1000000, 0, 1 << 16, 3)); // std above remainder
        send_stats(make_stats(1, 1000, 1000, 0, 49, 0, 2 << 16, 2));     // runtime equals mean
        send_stats(make_stats(16'hFFFF, 0, m32, m32, m48, m48, m32, 1)); // largest stats, quotient saturates
        send_stats(make_stats(16'hFFFF, 0, m32, m32, m48, m48, m32, m32));
        send_stats(make_stats(2, 0, m32, m32, 0, 0, 0, 1));              // quotient overflow
        send_stats(make_stats(1, 0, m32, 0, 0, 0, 0, m32));              // max divisor
        send_stats(make_stats(1, 0, 0, 0, m48, 0, m32, 1));              // max alpha, max var
        send_stats(make_stats(5, 0, 0, 0, 0, m48, 1, 1));                // tiny alpha
        send_stats(make_stats(1, 0, 1, 0, 0, 0, 0, m32));                // quotient truncates
        send_stats(make_stats(10, 300, 800, 400, 2500, 1600, 3 << 15, 4));
        send_stats(make_stats(16'h8000, m32, 32'h8000_0000, 32'h5555_5555,
                              48'h8000_0000_0000, 48'h5555_5555_5555, 32'h8000_0000,
                              32'h8000_0000));
        send_stats(make_stats(16'h7FFF, 32'h7FFF_FFFF, 32'h2AAA_AAAA, 32'h7FFF_FFFF,
                              48'h7FFF_FFFF_FFFF, 48'h2AAA_AAAA_AAAA, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_stats(random_stats());
    endtask

    // receiver stalls far longer than the pipe is deep while items keep coming
    task automatic test_backpressure(int count);
        hold_cycles = LONG_HOLD;
        for (int i = 0; i < count; i++)
            send_stats(random_stats());
    endtask

    task automatic test_pause_and_drain();
        wait_drained();
        @(posedge clk);
        test_random(100);
    endtask

    task automatic test_full_rate(int count);
        quiet = 1'b1;
        for (int i = 0; i < count; i++)
            send_stats(random_stats());
    endtask

    initial
    begin
        errors      = 0;
        quiet       = 1'b0;
        hold_cycles = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(800);
        test_backpressure(300);
        test_pause_and_drain();
        test_random(400);
        test_full_rate(230);
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
